@@ rtl/csvh_pkg.sv @@
package csvh_pkg;

    // field widths of the result word
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 20;
    localparam int POP_W    = 32;
    localparam int NAME_W   = 8;
    localparam int HASH_W   = 9;
    localparam int LINE_W   = 8;

    localparam int HASH_BUCKETS = 400;
    localparam int MAX_LINE     = 200;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;
    localparam logic [POP_W-1:0]  POP_MAX  = '1;

    // reciprocal for the product remainder: q = (p * PROD_RECIP) >> PROD_SHIFT
    localparam int PROD_W     = 16;
    localparam int PROD_SHIFT = 25;
    localparam int RECIP_W    = 17;
    localparam int QUOT_W     = 8;
    localparam logic [RECIP_W-1:0] PROD_RECIP =
        RECIP_W'((2**PROD_SHIFT + HASH_BUCKETS - 1) / HASH_BUCKETS);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MISSING   = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_COMMA,
        CLS_QUOTE,
        CLS_PAREN,
        CLS_OTHER
    } byte_class_t;

    // one classified byte in the queue
    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic [7:0]  data;
        logic        last;
    } line_entry_t;

endpackage

@@ rtl/csvh_front.sv @@
module csvh_front
    import csvh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    output logic        q_valid,
    input  logic        q_ready,
    output line_entry_t q_entry
);

    line_entry_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    line_entry_t in_entry;
    logic        push, pop;

    always_comb begin
        in_entry.data  = s_tdata;
        in_entry.last  = s_tlast;
        in_entry.digit = 4'(s_tdata - 8'h30);
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
            in_entry.cls = CLS_DIGIT;
        end else if (s_tdata == 8'h2C) begin
            in_entry.cls = CLS_COMMA;
        end else if (s_tdata == 8'h22) begin
            in_entry.cls = CLS_QUOTE;
        end else if (s_tdata == 8'h28) begin
            in_entry.cls = CLS_PAREN;
        end else begin
            in_entry.cls = CLS_OTHER;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

@@ rtl/csvh_back.sv @@
module csvh_back
    import csvh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  line_entry_t q_entry,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser
);

    typedef enum logic [10:0] {
        PH_START       = 11'b000_0000_0001,
        PH_RANK        = 11'b000_0000_0010,
        PH_OPEN_NAME   = 11'b000_0000_0100,
        PH_NAME        = 11'b000_0000_1000,
        PH_AFTER_NAME  = 11'b000_0001_0000,
        PH_POP_START   = 11'b000_0010_0000,
        PH_POP_EMPTY   = 11'b000_0100_0000,
        PH_POP_DIGITS  = 11'b000_1000_0000,
        PH_ACCEPT      = 11'b001_0000_0000,
        PH_ACCEPT_MISS = 11'b010_0000_0000,
        PH_ERROR       = 11'b100_0000_0000
    } phase_t;

    localparam int RANK_EXT_W = RANK_W + 4;
    localparam int POP_EXT_W  = POP_W + 4;

    phase_t              phase_reg, phase_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [POP_W-1:0]    pop_reg, pop_next;
    logic [NAME_W-1:0]   name_count_reg, name_count_next;
    logic [HASH_W-1:0]   sum_reg, sum_next;
    logic [7:0]          first_byte_reg, first_byte_next;
    logic [LINE_W-1:0]   line_count_reg, line_count_next;

    logic [PROD_W-1:0]   prod_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [HASH_W-1:0]   prod_mod_reg;
    logic                load_prod;

    logic                m_tvalid_reg;
    logic [87:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic                step;
    logic [RANK_EXT_W-1:0] rank_ext;
    logic [POP_EXT_W-1:0]  pop_ext;
    logic [HASH_W:0]       sum_ext;
    logic [HASH_W:0]       len_ext;
    logic                  terminal;

    logic                accepted;
    status_t             res_status;
    logic [RANK_W-1:0]   res_rank;
    logic [POP_W-1:0]    res_pop;
    logic [NAME_W-1:0]   res_name_len;
    logic [HASH_W-1:0]   res_hash_len;
    logic [HASH_W-1:0]   res_hash_sum;
    logic [HASH_W-1:0]   res_hash_prod;

    // a line end needs the output slot free or draining this cycle
    assign q_ready = !q_entry.last || !m_tvalid_reg || m_tready;
    assign step    = q_valid && q_ready;

    // saturating decimal accumulate: acc * 10 + digit
    assign rank_ext = (RANK_EXT_W'(rank_reg) << 3) + (RANK_EXT_W'(rank_reg) << 1)
                      + RANK_EXT_W'(q_entry.digit);
    assign pop_ext  = (POP_EXT_W'(pop_reg) << 3) + (POP_EXT_W'(pop_reg) << 1)
                      + POP_EXT_W'(q_entry.digit);
    assign sum_ext  = (HASH_W+1)'(sum_reg) + (HASH_W+1)'(q_entry.data);

    assign terminal = (phase_reg == PH_ACCEPT) || (phase_reg == PH_ACCEPT_MISS)
                      || (phase_reg == PH_ERROR);

    always_comb begin
        phase_next      = phase_reg;
        rank_next       = rank_reg;
        pop_next        = pop_reg;
        name_count_next = name_count_reg;
        sum_next        = sum_reg;
        first_byte_next = first_byte_reg;
        line_count_next = line_count_reg;
        load_prod       = 1'b0;
        if (step && !terminal) begin
            if (line_count_reg >= LINE_W'(MAX_LINE - 1)) begin
                phase_next = PH_ERROR;
            end else begin
                line_count_next = line_count_reg + 1'b1;
                unique case (phase_reg) inside
                    PH_START: begin
                        if (q_entry.cls == CLS_DIGIT) begin
                            rank_next  = (rank_ext > RANK_EXT_W'(RANK_MAX)) ?
                                         RANK_MAX : rank_ext[RANK_W-1:0];
                            phase_next = PH_RANK;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_RANK: begin
                        if (q_entry.cls == CLS_DIGIT) begin
                            rank_next = (rank_ext > RANK_EXT_W'(RANK_MAX)) ?
                                        RANK_MAX : rank_ext[RANK_W-1:0];
                        end else if (q_entry.cls == CLS_COMMA) begin
                            phase_next = PH_OPEN_NAME;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_OPEN_NAME: begin
                        phase_next = (q_entry.cls == CLS_QUOTE) ? PH_NAME : PH_ERROR;
                    end
                    PH_NAME: begin
                        if (q_entry.cls == CLS_QUOTE) begin
                            phase_next = PH_AFTER_NAME;
                        end else begin
                            if (name_count_reg == '0) begin
                                first_byte_next = q_entry.data;
                            end
                            load_prod       = (name_count_reg == NAME_W'(1));
                            name_count_next = name_count_reg + 1'b1;
                            sum_next        = (sum_ext >= (HASH_W+1)'(HASH_BUCKETS)) ?
                                HASH_W'(sum_ext - (HASH_W+1)'(HASH_BUCKETS)) :
                                HASH_W'(sum_ext);
                        end
                    end
                    PH_AFTER_NAME: begin
                        phase_next = (q_entry.cls == CLS_COMMA) ? PH_POP_START : PH_ERROR;
                    end
                    PH_POP_START: begin
                        if (q_entry.cls == CLS_QUOTE) begin
                            phase_next = PH_POP_EMPTY;
                        end else if (q_entry.cls == CLS_PAREN) begin
                            pop_next   = '0;
                            phase_next = PH_ACCEPT_MISS;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_POP_EMPTY, PH_POP_DIGITS: begin
                        if (q_entry.cls == CLS_DIGIT) begin
                            pop_next   = (pop_ext > POP_EXT_W'(POP_MAX)) ?
                                         POP_MAX : pop_ext[POP_W-1:0];
                            phase_next = PH_POP_DIGITS;
                        end else if (q_entry.cls == CLS_COMMA) begin
                            phase_next = phase_reg;
                        end else if (q_entry.cls == CLS_QUOTE) begin
                            phase_next = (phase_reg == PH_POP_DIGITS) ? PH_ACCEPT : PH_ERROR;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    default: begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // result word, built from the state after the line's last byte
    assign len_ext  = (HASH_W+1)'(name_count_next);
    assign accepted = (phase_next == PH_ACCEPT) || (phase_next == PH_ACCEPT_MISS);

    always_comb begin
        res_status    = ST_MALFORMED;
        res_rank      = '0;
        res_pop       = '0;
        res_name_len  = '0;
        res_hash_len  = '0;
        res_hash_sum  = '0;
        res_hash_prod = '0;
        if (accepted) begin
            res_status    = (phase_next == PH_ACCEPT) ? ST_OK : ST_MISSING;
            res_rank      = rank_next;
            res_pop       = (phase_next == PH_ACCEPT) ? pop_next : '0;
            res_name_len  = name_count_next;
            res_hash_len  = (len_ext >= (HASH_W+1)'(HASH_BUCKETS)) ?
                            HASH_W'(len_ext - (HASH_W+1)'(HASH_BUCKETS)) : HASH_W'(len_ext);
            res_hash_sum  = sum_next;
            res_hash_prod = (name_count_next >= NAME_W'(2)) ? prod_mod_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            rank_reg       <= '0;
            pop_reg        <= '0;
            name_count_reg <= '0;
            sum_reg        <= '0;
            first_byte_reg <= '0;
            line_count_reg <= '0;
        end else if (step && q_entry.last) begin
            phase_reg      <= PH_START;
            rank_reg       <= '0;
            pop_reg        <= '0;
            name_count_reg <= '0;
            sum_reg        <= '0;
            first_byte_reg <= '0;
            line_count_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            rank_reg       <= rank_next;
            pop_reg        <= pop_next;
            name_count_reg <= name_count_next;
            sum_reg        <= sum_next;
            first_byte_reg <= first_byte_next;
            line_count_reg <= line_count_next;
        end
    end

    // product remainder via prod_reg, quot_reg, prod_mod_reg from the
    // second name byte; the third byte after it can first accept a line
    always_ff @(posedge aclk) begin
        if (load_prod) begin
            prod_reg <= PROD_W'(first_byte_reg) * PROD_W'(q_entry.data);
        end
        quot_reg     <= QUOT_W'(((PROD_W+RECIP_W)'(prod_reg) *
                                 (PROD_W+RECIP_W)'(PROD_RECIP)) >> PROD_SHIFT);
        prod_mod_reg <= HASH_W'((PROD_W+1)'(prod_reg) -
                                (PROD_W+1)'(quot_reg) * (PROD_W+1)'(HASH_BUCKETS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step && q_entry.last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && q_entry.last) begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {1'b0, res_hash_prod, res_hash_sum, res_hash_len,
                            res_name_len, res_pop, res_rank};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/csv_city_line_parser_hasher.sv @@
// Parses text lines of the form rank,"city",population one byte per word and
// returns one result word per line, on the word marked tlast. The population
// is either a quoted number (commas inside it are skipped) or an opening
// parenthesis meaning missing. A classifier front end feeds a two-word queue;
// the parser behind it takes one byte per clock, so the block sustains one
// input word per cycle while results are taken. A line's last byte passes
// through the queue and then the output register into its result, and a line
// end stalls only while an earlier result is still waiting. m_tuser carries
// the status: ok, ok with missing population, or malformed (all other
// fields zero). Hashes of the name use 400 buckets: length, byte sum, and
// the product of the first two name bytes (zero for names under two bytes).
// Lines of more than 199 bytes before acceptance count as malformed.
module csv_city_line_parser_hasher
    import csvh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // line input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // line_byte
    input  logic        s_tlast,   // end_of_line
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // rank, population, name_length, hash_length,
                                   // hash_sum, hash_product, zero pad
    output logic [1:0]  m_tuser    // status
);

    logic        q_valid;
    logic        q_ready;
    line_entry_t q_entry;

    // byte classifier and queue
    csvh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    // line parser, accumulators, hashes and output register
    csvh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
